// ----- rtl/cfb_pkg.sv -----
package cfb_pkg;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [16:0] FRAME_OVERHEAD = 17'd9;
  localparam logic [16:0] MAX_FRAME_RESET = 17'd180;

  localparam int BURST_DEPTH = 9;

  localparam logic [1:0] REG_MAGIC_FIRST = 2'd0;
  localparam logic [1:0] REG_MAGIC_SECOND = 2'd1;
  localparam logic [1:0] REG_MAX_FRAME = 2'd2;

  typedef struct packed {
    logic        is_header;
    logic [7:0]  frame_type;
    logic [7:0]  session_id;
    logic [7:0]  sequence_req;
    logic [15:0] payload_length;
    logic [7:0]  payload_byte;
  } cfb_item_t;

  // One byte through CRC-16/CCITT, MSB first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {data, 8'h00};
    for (int b = 0; b < 8; b++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- rtl/cfb_if.sv -----
interface cfb_item_if;
  logic        valid;
  logic        ready;
  logic        is_header;
  logic [7:0]  frame_type;
  logic [7:0]  session_id;
  logic [7:0]  sequence_req;
  logic [15:0] payload_length;
  logic [7:0]  payload_byte;

  modport source (
    output valid, is_header, frame_type, session_id, sequence_req, payload_length,
           payload_byte,
    input  ready
  );
  modport sink (
    input  valid, is_header, frame_type, session_id, sequence_req, payload_length,
           payload_byte,
    output ready
  );
endinterface

interface cfb_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       end_of_frame;

  modport source (
    output valid, frame_byte, end_of_frame,
    input  ready
  );
  modport sink (
    input  valid, frame_byte, end_of_frame,
    output ready
  );
endinterface

// ----- rtl/crc_frame_builder_top.sv -----
// Each accepted transaction goes via the item FIFO into the output burst register.
// Throughput: one payload transaction per cycle while the output accepts; a header that
// fits max frame size yields 7 output bytes (9 with empty payload), the last payload
// byte 3, one byte per cycle, so the output port sets the pace during those bursts.
// Reset (rst, synchronous): empties the input buffer and output burst, closes any
// frame, CRC to 0xFFFF; registers to magic 0/0 and max frame size 180.
module crc_frame_builder_top (
  input  logic        clk,
  input  logic        rst,
  cfb_item_if.sink    item,
  cfb_result_if.source result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import cfb_pkg::*;

  logic [7:0]  magic_first;
  logic [7:0]  magic_second;
  logic [16:0] max_frame_bytes;
  logic [15:0] magic_crc;

  logic [15:0] crc_acc;
  logic [15:0] remaining;
  logic        frame_open;
  logic        frame_dropping;

  logic [7:0]  burst [BURST_DEPTH];
  logic [3:0]  burst_cnt;
  logic        burst_eof;

  logic        head_valid;
  cfb_item_t   head;
  logic        pop;
  logic        take;

  logic [15:0] crc_acc_next;
  logic [15:0] remaining_next;
  logic        frame_open_next;
  logic        frame_dropping_next;
  logic [7:0]  burst_next [BURST_DEPTH];
  logic [3:0]  burst_cnt_next;
  logic        burst_eof_next;
  logic [15:0] c;
  logic [15:0] rem_dec;

  cfb_item_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // Configuration
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      magic_first     <= 8'd0;
      magic_second    <= 8'd0;
      max_frame_bytes <= MAX_FRAME_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[3:2])
        REG_MAGIC_FIRST:  magic_first <= pwdata[7:0];
        REG_MAGIC_SECOND: magic_second <= pwdata[7:0];
        REG_MAX_FRAME:    max_frame_bytes <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_MAGIC_FIRST:  prdata = {24'd0, magic_first};
      REG_MAGIC_SECOND: prdata = {24'd0, magic_second};
      REG_MAX_FRAME:    prdata = {15'd0, max_frame_bytes};
      default:          prdata = 32'd0;
    endcase
  end

  // CRC over the two sync bytes, kept ready for the next header
  always_ff @(posedge clk) begin
    magic_crc <= crc_byte(crc_byte(CRC_INIT, magic_first), magic_second);
  end

  // Output burst
  assign result.valid = (burst_cnt != 4'd0);
  assign result.frame_byte = burst[0];
  assign result.end_of_frame = burst_eof && (burst_cnt == 4'd1);
  assign take = result.valid && result.ready;
  assign pop = head_valid && ((burst_cnt == 4'd0) || ((burst_cnt == 4'd1) && result.ready));

  always_comb begin
    crc_acc_next        = crc_acc;
    remaining_next      = remaining;
    frame_open_next     = frame_open;
    frame_dropping_next = frame_dropping;
    burst_cnt_next      = 4'd0;
    burst_eof_next      = 1'b0;
    for (int i = 0; i < BURST_DEPTH; i++) begin
      burst_next[i] = 8'd0;
    end
    c       = magic_crc;
    rem_dec = remaining - 16'd1;

    if (head.is_header) begin
      frame_open_next     = 1'b0;
      frame_dropping_next = 1'b0;
      crc_acc_next        = CRC_INIT;
      remaining_next      = 16'd0;
      if (({1'b0, head.payload_length} + FRAME_OVERHEAD) > max_frame_bytes) begin
        if (head.payload_length != 16'd0) begin
          frame_dropping_next = 1'b1;
          remaining_next      = head.payload_length;
        end
      end else begin
        c = crc_byte(c, head.frame_type);
        c = crc_byte(c, head.session_id);
        c = crc_byte(c, head.sequence_req);
        c = crc_byte(c, head.payload_length[7:0]);
        c = crc_byte(c, head.payload_length[15:8]);
        burst_next[0] = magic_first;
        burst_next[1] = magic_second;
        burst_next[2] = head.frame_type;
        burst_next[3] = head.session_id;
        burst_next[4] = head.sequence_req;
        burst_next[5] = head.payload_length[7:0];
        burst_next[6] = head.payload_length[15:8];
        if (head.payload_length == 16'd0) begin
          burst_next[7]  = c[7:0];
          burst_next[8]  = c[15:8];
          burst_cnt_next = 4'd9;
          burst_eof_next = 1'b1;
        end else begin
          frame_open_next = 1'b1;
          remaining_next  = head.payload_length;
          crc_acc_next    = c;
          burst_cnt_next  = 4'd7;
        end
      end
    end else if (frame_dropping) begin
      remaining_next = rem_dec;
      if (rem_dec == 16'd0) begin
        frame_dropping_next = 1'b0;
      end
    end else if (frame_open) begin
      c              = crc_byte(crc_acc, head.payload_byte);
      burst_next[0]  = head.payload_byte;
      remaining_next = rem_dec;
      if (rem_dec == 16'd0) begin
        burst_next[1]   = c[7:0];
        burst_next[2]   = c[15:8];
        burst_cnt_next  = 4'd3;
        burst_eof_next  = 1'b1;
        frame_open_next = 1'b0;
        crc_acc_next    = CRC_INIT;
      end else begin
        crc_acc_next   = c;
        burst_cnt_next = 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_acc        <= CRC_INIT;
      remaining      <= 16'd0;
      frame_open     <= 1'b0;
      frame_dropping <= 1'b0;
      burst_cnt      <= 4'd0;
      burst_eof      <= 1'b0;
    end else if (pop) begin
      crc_acc        <= crc_acc_next;
      remaining      <= remaining_next;
      frame_open     <= frame_open_next;
      frame_dropping <= frame_dropping_next;
      burst_cnt      <= burst_cnt_next;
      burst_eof      <= burst_eof_next;
    end else if (take) begin
      burst_cnt <= burst_cnt - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      burst <= burst_next;
    end else if (take) begin
      for (int i = 0; i < BURST_DEPTH - 1; i++) begin
        burst[i] <= burst[i + 1];
      end
      burst[BURST_DEPTH - 1] <= 8'd0;
    end
  end

endmodule

// ----- rtl/cfb_item_fifo.sv -----
module cfb_item_fifo (
  input  logic               clk,
  input  logic               rst,
  cfb_item_if.sink           item,
  input  logic               pop,
  output logic               head_valid,
  output cfb_pkg::cfb_item_t head
);
  import cfb_pkg::*;

  cfb_item_t  entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       do_pop;

  assign item.ready = (count != 2'd2);
  assign push = item.valid && item.ready;
  assign head_valid = (count != 2'd0);
  assign head = entries[rd_ptr];
  assign do_pop = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= '{
        is_header:      item.is_header,
        frame_type:     item.frame_type,
        session_id:     item.session_id,
        sequence_req:   item.sequence_req,
        payload_length: item.payload_length,
        payload_byte:   item.payload_byte
      };
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
